// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FMD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define FMD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define FMD_ASSERT(lbl, clk, rst, prop)

`define FMD_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ===== hdl/fmd_pkg.sv =====
// ----------------------------------------------------------------------------
// FM discriminator package
// Widths, constants, angle table and shared types.
// ----------------------------------------------------------------------------
package fmd_pkg;

   localparam int IQ_W         = 8;
   localparam int PHASE_W      = 16;
   localparam int RATE_W       = 16;
   localparam int FREQ_W       = 16;
   localparam int CORDIC_STEPS = 15;
   localparam int XY_W         = 27;
   localparam int ANG_W        = 18;
   localparam int IQ_SHIFT     = 16;
   localparam int DIFF_W       = PHASE_W + 1;
   localparam int PROD_W       = PHASE_W + RATE_W + 1;
   localparam int ABS_W        = 30;
   localparam int DIV_SHIFT    = 15;
   localparam int QUO_W        = 16;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;

   localparam logic [RATE_W-1:0]        RATE_RESET = 16'd48000;
   localparam logic signed [ANG_W-1:0]  HALF_TURN  = 18'sd32768;
   localparam logic signed [DIFF_W-1:0] WRAP_LIMIT = 17'sd32767;
   localparam logic signed [DIFF_W-1:0] WRAP_SPAN  = 17'sd65534;
   localparam logic [DIV_SHIFT:0]       DIV_CONST  = 16'd32767;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               record_only;
   } fmd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fmd_qstat_type;

   function automatic logic signed [ANG_W-1:0] atan_step(input int k);
      logic signed [ANG_W-1:0] a;
      unique case (k)
         0:       a = 18'sd8192;
         1:       a = 18'sd4836;
         2:       a = 18'sd2555;
         3:       a = 18'sd1297;
         4:       a = 18'sd651;
         5:       a = 18'sd326;
         6:       a = 18'sd163;
         7:       a = 18'sd81;
         8:       a = 18'sd41;
         9:       a = 18'sd20;
         10:      a = 18'sd10;
         11:      a = 18'sd5;
         12:      a = 18'sd3;
         13:      a = 18'sd1;
         14:      a = 18'sd1;
         default: a = 18'sd0;
      endcase
      return a;
   endfunction

endpackage

// ===== hdl/iq_phase_difference_fm_discriminator.sv =====
// ----------------------------------------------------------------------------
// I/Q phase difference FM discriminator
// CORDIC phase per I/Q word, wrapped phase difference scaled to Hz.
// ----------------------------------------------------------------------------
// Throughput: one word per clock without back pressure; the CORDIC pipeline
// holds while its last stage is valid and the queue is full, the 5-stage back
// end holds while a result waits on rsp_tready; a 4-entry queue sits between them.
// Reset: synchronous; clears the pipelines, the queue and the previous phase,
// and sets the sample rate to 48000.
module iq_phase_difference_fm_discriminator import fmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] in_phase, [15:8] quadrature
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] frequency
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // [15:0] rate_hz
);

   logic [RATE_W-1:0] rate_hz_ff, rate_hz_in;
   fmd_qstat_type     qstat;
   fmd_entry_type     push_entry, pop_entry;
   logic              push, pop;

   assign csr_ready  = 1'b1;
   assign rate_hz_in = (csr_valid && csr_ready) ? csr_data : rate_hz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_hz_ff <= RATE_RESET;
      end else begin
         rate_hz_ff <= rate_hz_in;
      end
   end

   fmd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   fmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   fmd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .qstat       (qstat),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rate_hz     (rate_hz_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== hdl/fmd_front.sv =====
// ----------------------------------------------------------------------------
// FM discriminator front end
// Accepts I/Q words, marks record-only words and runs a pipelined CORDIC.
// ----------------------------------------------------------------------------
module fmd_front import fmd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // [7:0] in_phase, [15:8] quadrature
   input  logic          req_tuser,   // [0] restart
   input  fmd_qstat_type qstat,
   output logic          push,
   output fmd_entry_type push_entry
);

   localparam int LAST = CORDIC_STEPS;

   logic signed [XY_W-1:0]  x_ff [0:LAST];
   logic signed [XY_W-1:0]  x_in [0:LAST];
   logic signed [XY_W-1:0]  y_ff [0:LAST];
   logic signed [XY_W-1:0]  y_in [0:LAST];
   logic signed [ANG_W-1:0] z_ff [0:LAST];
   logic signed [ANG_W-1:0] z_in [0:LAST];
   logic [LAST:0]           zero_ff, zero_in;
   logic [LAST:0]           rec_ff, rec_in;
   logic [LAST:0]           vld_ff, vld_in;
   logic                    have_last_ff, have_last_in;

   logic                    advance;
   logic                    accept;
   logic signed [IQ_W:0]    i_ext, q_ext, i_rot, q_rot;
   logic                    i_neg;

   assign advance    = !(vld_ff[LAST] && qstat.full);
   assign accept     = req_tvalid && advance;
   assign req_tready = advance;

   always_comb begin
      i_ext = {req_tdata[IQ_W-1], req_tdata[IQ_W-1:0]};
      q_ext = {req_tdata[2*IQ_W-1], req_tdata[2*IQ_W-1:IQ_W]};
      i_neg = i_ext[IQ_W];
      i_rot = i_neg ? -i_ext : i_ext;
      q_rot = i_neg ? -q_ext : q_ext;

      x_in[0]    = {{(XY_W-IQ_W-1-IQ_SHIFT){i_rot[IQ_W]}}, i_rot, {IQ_SHIFT{1'b0}}};
      y_in[0]    = {{(XY_W-IQ_W-1-IQ_SHIFT){q_rot[IQ_W]}}, q_rot, {IQ_SHIFT{1'b0}}};
      z_in[0]    = !i_neg ? '0 : (q_ext[IQ_W] ? -HALF_TURN : HALF_TURN);
      zero_in[0] = (i_ext == '0) && (q_ext == '0);
      rec_in[0]  = req_tuser || !have_last_ff;
      vld_in[0]  = req_tvalid;

      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (!y_ff[k][XY_W-1]) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + atan_step(k);
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - atan_step(k);
         end
         zero_in[k+1] = zero_ff[k];
         rec_in[k+1]  = rec_ff[k];
         vld_in[k+1]  = vld_ff[k];
      end

      have_last_in = have_last_ff || accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         have_last_ff <= 1'b0;
      end else begin
         have_last_ff <= have_last_in;
         if (advance) begin
            vld_ff <= vld_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= zero_in;
         rec_ff  <= rec_in;
      end
   end

   assign push                   = vld_ff[LAST] && !qstat.full;
   assign push_entry.phase       = zero_ff[LAST] ? '0 : z_ff[LAST][PHASE_W-1:0];
   assign push_entry.record_only = rec_ff[LAST];

endmodule

// ===== hdl/fmd_queue.sv =====
// ----------------------------------------------------------------------------
// FM discriminator phase queue
// Short FIFO of phase words between the CORDIC and the frequency back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmd_queue import fmd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  fmd_entry_type push_entry,
   input  logic          pop,
   output fmd_entry_type pop_entry,
   output fmd_qstat_type qstat
);

   fmd_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry   = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   `FMD_ASSERT_NEVER(a_no_overflow, clock, reset, push && qstat.full)
   `FMD_ASSERT_NEVER(a_no_underflow, clock, reset, pop && qstat.empty)
   `FMD_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `FMD_ASSERT(a_ptr_gap, clock, reset, QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])

endmodule

// ===== hdl/fmd_back.sv =====
// ----------------------------------------------------------------------------
// FM discriminator back end
// Phase difference, wrap, scale by sample rate and divide by 65534.
// ----------------------------------------------------------------------------
module fmd_back import fmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  fmd_qstat_type     qstat,
   input  fmd_entry_type     pop_entry,
   output logic              pop,
   input  logic [RATE_W-1:0] rate_hz,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata    // [15:0] frequency
);

   logic                       advance;

   logic [PHASE_W-1:0]         last_phase_ff, last_phase_in;
   logic                       v1_ff, v1_in, v2_ff, v3_ff, v4_ff;
   logic                       rsp_valid_ff;
   logic signed [PHASE_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [ABS_W-1:0]           a3_ff, a3_in, a4_ff;
   logic                       neg3_ff, neg3_in, neg4_ff;
   logic [QUO_W-1:0]           q0_ff, q0_in;
   logic [FREQ_W-1:0]          rsp_data_ff, rsp_data_in;

   logic signed [DIFF_W-1:0]   d_raw, d_wrap;
   logic signed [RATE_W:0]     rate_s;
   logic [PROD_W-1:0]          mag;
   logic [ABS_W:0]             est;
   logic [ABS_W:0]             rem;
   logic [QUO_W-1:0]           quo;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign pop     = advance && !qstat.empty;

   always_comb begin
      d_raw = $signed({pop_entry.phase[PHASE_W-1], pop_entry.phase})
            - $signed({last_phase_ff[PHASE_W-1], last_phase_ff});
      priority if (d_raw > WRAP_LIMIT) begin
         d_wrap = d_raw - WRAP_SPAN;
      end else if (d_raw < -WRAP_LIMIT) begin
         d_wrap = d_raw + WRAP_SPAN;
      end else begin
         d_wrap = d_raw;
      end
      diff_in       = d_wrap[PHASE_W-1:0];
      v1_in         = pop && !pop_entry.record_only;
      last_phase_in = pop ? pop_entry.phase : last_phase_ff;

      rate_s  = $signed({1'b0, rate_hz});
      prod_in = diff_ff * rate_s;

      mag     = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      a3_in   = mag[ABS_W:1];
      neg3_in = prod_ff[PROD_W-1];

      est   = {1'b0, a3_ff} + (ABS_W+1)'(a3_ff >> DIV_SHIFT);
      q0_in = est[ABS_W:DIV_SHIFT];

      rem = {1'b0, a4_ff} - {q0_ff, {DIV_SHIFT{1'b0}}} + (ABS_W+1)'(q0_ff);
      quo = (rem >= (ABS_W+1)'(DIV_CONST)) ? q0_ff + 1'b1 : q0_ff;
      rsp_data_in = neg4_ff ? FREQ_W'(-quo) : FREQ_W'(quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         last_phase_ff <= last_phase_in;
         v1_ff         <= v1_in;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         rsp_valid_ff  <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff     <= diff_in;
         prod_ff     <= prod_in;
         a3_ff       <= a3_in;
         neg3_ff     <= neg3_in;
         a4_ff       <= a3_ff;
         neg4_ff     <= neg3_ff;
         q0_ff       <= q0_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
